// ----- hw/rtl/positional_list_engine_defines.svh -----
// ----------------------------------------------------------------------------
// Positional list engine: assertion macros
// Shared property shorthands, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define PLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// ple_pkg
// Widths, command codes and shared structures of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CMD_W     = 2;
  localparam int CNT_W     = 8;
  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 128;

  localparam logic [CNT_W-1:0] CAP_RESET = 8'd128;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_GET    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LOCATE = 2'd3;

  // One cycle of traffic to the entry store
  typedef struct packed {
    logic              rd_en;
    logic [CNT_W-1:0]  rd_idx;
    logic              wr_en;
    logic [CNT_W-1:0]  wr_idx;
    logic [DATA_W-1:0] wr_data;
  } mem_req_t;

  // One result item
  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         found_position;
    logic [CNT_W-1:0]         list_length;
    logic                     is_empty;
  } res_t;

endpackage

// ----- hw/rtl/ple_mem.sv -----
// ----------------------------------------------------------------------------
// ple_mem
// Entry store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ple_mem
  import ple_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  mem_req_t          req,
  output logic [DATA_W-1:0] rd_data
);

  localparam int AW = $clog2(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[AW'(req.wr_idx)] <= req.wr_data;
    end
  end

  // Read port, read data registered
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[AW'(req.rd_idx)];
    end
  end

endmodule

// ----- hw/rtl/ple_seq.sv -----
// ----------------------------------------------------------------------------
// ple_seq
// Command sequencer: checks each item, walks the store one entry per cycle
// for shifts and searches, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module ple_seq
  import ple_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic [CNT_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [CNT_W-1:0]         cap_limit,
  output mem_req_t                 mem_req,
  input  logic [DATA_W-1:0]        rd_data,
  output logic                     res_valid,
  input  logic                     res_take,
  output res_t                     res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UP   = 3'd1;
  localparam logic [2:0] S_DOWN = 3'd2;
  localparam logic [2:0] S_GET  = 3'd3;
  localparam logic [2:0] S_FIND = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              shift_r, shift_nxt;
  logic [CNT_W-1:0]  pidx_r, pidx_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic              ok_r, ok_nxt;
  logic [DATA_W-1:0] rdv_r, rdv_nxt;
  logic [CNT_W-1:0]  found_r, found_nxt;

  logic [CNT_W-1:0]  pos_idx;
  logic              in_list;
  logic              ins_ok;

  assign in_ready = (state_r == S_IDLE);
  assign pos_idx  = in_position - 8'd1;
  assign in_list  = (in_position != '0) && (in_position <= cnt_r);
  assign ins_ok   = (in_position != '0)
                 && ({1'b0, in_position} <= ({1'b0, cnt_r} + 9'd1))
                 && (cnt_r < cap_limit)
                 && (int'(cnt_r) < DEPTH);

  // Sequence the commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    pidx_nxt  = pidx_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    ok_nxt    = ok_r;
    rdv_nxt   = rdv_r;
    found_nxt = found_r;
    mem_req   = '0;
    res_valid = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ok_nxt    = 1'b0;
          rdv_nxt   = '0;
          found_nxt = '0;
          val_nxt   = in_value;
          pos_nxt   = pos_idx;
          state_nxt = S_DONE;
          unique case (in_cmd)
            CMD_GET: begin
              if (in_list) begin
                ok_nxt         = 1'b1;
                mem_req.rd_en  = 1'b1;
                mem_req.rd_idx = pos_idx;
                state_nxt      = S_GET;
              end
            end
            CMD_INSERT: begin
              if (ins_ok) begin
                ok_nxt = 1'b1;
                if (pos_idx == cnt_r) begin
                  // Append: no entries to move
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_idx  = cnt_r;
                  mem_req.wr_data = in_value;
                  cnt_nxt         = cnt_r + 8'd1;
                end else begin
                  mem_req.rd_en  = 1'b1;
                  mem_req.rd_idx = cnt_r - 8'd1;
                  pidx_nxt       = cnt_r - 8'd1;
                  shift_nxt      = 1'b1;
                  state_nxt      = S_UP;
                end
              end
            end
            CMD_DELETE: begin
              if (in_list) begin
                ok_nxt         = 1'b1;
                mem_req.rd_en  = 1'b1;
                mem_req.rd_idx = pos_idx;
                pidx_nxt       = pos_idx;
                state_nxt      = S_DOWN;
              end
            end
            CMD_LOCATE: begin
              ok_nxt = 1'b1;
              if (cnt_r != '0) begin
                mem_req.rd_en  = 1'b1;
                mem_req.rd_idx = '0;
                pidx_nxt       = '0;
                state_nxt      = S_FIND;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      // Move entries up from the tail, then drop the new value in
      S_UP: begin
        if (shift_r) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_idx  = pidx_r + 8'd1;
          mem_req.wr_data = rd_data;
          if (pidx_r != pos_r) begin
            mem_req.rd_en  = 1'b1;
            mem_req.rd_idx = pidx_r - 8'd1;
            pidx_nxt       = pidx_r - 8'd1;
          end else begin
            shift_nxt = 1'b0;
          end
        end else begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_idx  = pos_r;
          mem_req.wr_data = val_r;
          cnt_nxt         = cnt_r + 8'd1;
          state_nxt       = S_DONE;
        end
      end

      // Capture the removed value, then move later entries down
      S_DOWN: begin
        if (pidx_r == pos_r) begin
          rdv_nxt = rd_data;
        end else begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_idx  = pidx_r - 8'd1;
          mem_req.wr_data = rd_data;
        end
        if ((pidx_r + 8'd1) < cnt_r) begin
          mem_req.rd_en  = 1'b1;
          mem_req.rd_idx = pidx_r + 8'd1;
          pidx_nxt       = pidx_r + 8'd1;
        end else begin
          cnt_nxt   = cnt_r - 8'd1;
          state_nxt = S_DONE;
        end
      end

      S_GET: begin
        rdv_nxt   = rd_data;
        state_nxt = S_DONE;
      end

      // Scan from the head, stop at the first match
      S_FIND: begin
        if (rd_data == val_r) begin
          found_nxt = pidx_r + 8'd1;
          state_nxt = S_DONE;
        end else if ((pidx_r + 8'd1) < cnt_r) begin
          mem_req.rd_en  = 1'b1;
          mem_req.rd_idx = pidx_r + 8'd1;
          pidx_nxt       = pidx_r + 8'd1;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      shift_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      shift_r <= shift_nxt;
    end
  end

  // Working payload
  always_ff @(posedge clk) begin
    pidx_r  <= pidx_nxt;
    pos_r   <= pos_nxt;
    val_r   <= val_nxt;
    ok_r    <= ok_nxt;
    rdv_r   <= rdv_nxt;
    found_r <= found_nxt;
  end

  assign res.ok             = ok_r;
  assign res.read_value     = rdv_r;
  assign res.found_position = found_r;
  assign res.list_length    = cnt_r;
  assign res.is_empty       = (cnt_r == '0);

endmodule

// ----- hw/rtl/positional_list_engine.sv -----
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit values with 1-based get, insert, delete and
// locate, held in a single-port-pair entry store.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command item (cmd, position, value) per valid/ready handshake.
//   out_* : one result item per command, valid/ready, held in an output
//           register so the engine may start the next item while it waits.
//   cfg_* : writes capacity_limit at any handshake; always ready.
// Shifts and searches go through the store's single read port, one entry per
//   cycle; the next item is taken once the previous result has moved to the
//   output register.
// Reset clears the length to zero and capacity_limit to 128; entries need no
//   clearing as only written positions are ever read.
// While out_ready is low the result stays in the output register; one more
//   finished result waits inside the engine and no further item is taken.
// ----------------------------------------------------------------------------
`include "positional_list_engine_defines.svh"

module positional_list_engine
  import ple_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic [CNT_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_ok,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic [CNT_W-1:0]         out_found_position,
  output logic [CNT_W-1:0]         out_list_length,
  output logic                     out_is_empty,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CNT_W-1:0]         cfg_data
);

  logic [CNT_W-1:0]  cap_r;
  mem_req_t          mem_req;
  logic [DATA_W-1:0] rd_data;
  logic              res_valid;
  logic              res_take;
  res_t              res;
  logic              out_valid_r;
  res_t              out_r;

  // Capacity register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid) begin
      cap_r <= cfg_data;
    end
  end

  ple_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_cmd      (in_cmd),
    .in_position (in_position),
    .in_value    (in_value),
    .cap_limit   (cap_r),
    .mem_req     (mem_req),
    .rd_data     (rd_data),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res)
  );

  ple_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Output register: load when empty or being drained
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ok             = out_r.ok;
  assign out_read_value     = out_r.read_value;
  assign out_found_position = out_r.found_position;
  assign out_list_length    = out_r.list_length;
  assign out_is_empty       = out_r.is_empty;

  // Checks
  `PLE_ASSERT_IMP(a_no_rw_overlap, mem_req.rd_en && mem_req.wr_en,
    mem_req.rd_idx != mem_req.wr_idx, "read and write hit the same entry")
  `PLE_ASSERT_IMP(a_wr_in_range, mem_req.wr_en, int'(mem_req.wr_idx) < DEPTH,
    "write beyond the store")
  `PLE_ASSERT_IMP(a_len_in_range, out_valid_r, int'(out_r.list_length) <= DEPTH,
    "list length beyond the store")
  `PLE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
    "item taken while the previous one is still at work")

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: positional list engine testbench
// Drives get, insert, delete and locate commands through the valid/ready
// input channel and writes capacity_limit between phases. A local model of the
// list predicts every result, which is then compared field by field with the
// result channel. Directed edge cases come first, then capacity and full-store
// checks, then random traffic with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  localparam int DEPTH          = DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 140;
  localparam int REPORT_LIMIT   = 10;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [CMD_W-1:0]         in_cmd;
  logic [CNT_W-1:0]         in_position;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_ready;
  logic                     out_ok;
  logic signed [DATA_W-1:0] out_read_value;
  logic [CNT_W-1:0]         out_found_position;
  logic [CNT_W-1:0]         out_list_length;
  logic                     out_is_empty;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CNT_W-1:0]         cfg_data;

  // List model: entries, length and capacity register
  logic signed [DATA_W-1:0] list_model [DEPTH];
  int                       model_len;
  logic [CNT_W-1:0]         model_cap;

  res_t pending_results [$];
  int   mismatch_count;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   quiet_cycles;

  positional_list_engine #(
    .DEPTH(DEPTH)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_position       (in_position),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ok            (out_ok),
    .out_read_value    (out_read_value),
    .out_found_position(out_found_position),
    .out_list_length   (out_list_length),
    .out_is_empty      (out_is_empty),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  always #5ns clk = ~clk;

  // Apply one command to the list model and return the result it must give
  function automatic res_t apply_command(input logic [CMD_W-1:0] cmd,
                                         input logic [CNT_W-1:0] pos,
                                         input logic signed [DATA_W-1:0] val);
    res_t r;
    int   p;
    int   room;
    p    = int'(pos);
    room = (int'(model_cap) < DEPTH) ? int'(model_cap) : DEPTH;
    r    = '0;
    case (cmd)
      CMD_GET: begin
        if (p >= 1 && p <= model_len) begin
          r.read_value = list_model[p-1];
          r.ok         = 1'b1;
        end
      end
      CMD_INSERT: begin
        if (p >= 1 && p <= model_len + 1 && model_len < room) begin
          for (int j = model_len; j >= p; j--) list_model[j] = list_model[j-1];
          list_model[p-1] = val;
          model_len++;
          r.ok = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (p >= 1 && p <= model_len) begin
          r.read_value = list_model[p-1];
          for (int j = p; j < model_len; j++) list_model[j-1] = list_model[j];
          model_len--;
          r.ok = 1'b1;
        end
      end
      default: begin
        r.ok = 1'b1;
        for (int j = 0; j < model_len; j++) begin
          if (list_model[j] == val) begin
            r.found_position = CNT_W'(j + 1);
            break;
          end
        end
      end
    endcase
    r.list_length = CNT_W'(model_len);
    r.is_empty    = (model_len == 0);
    return r;
  endfunction

  task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("mismatch on %s: expected %h, got %h", field, want, got);
    end
  endtask

  // Compare each result item with the oldest prediction
  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("result item with none expected: ok %b value %h len %0d",
                   out_ok, out_read_value, out_list_length);
      end else begin
        want = pending_results.pop_front();
        check_field("ok", DATA_W'(want.ok), DATA_W'(out_ok));
        check_field("read_value", want.read_value, out_read_value);
        check_field("found_position", DATA_W'(want.found_position),
                    DATA_W'(out_found_position));
        check_field("list_length", DATA_W'(want.list_length), DATA_W'(out_list_length));
        check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(out_is_empty));
      end
    end
  end

  // Stall the result channel at the current rate
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // End the run when no channel has moved an item for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Send one command item, with random gaps before it; called at a falling edge
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [CNT_W-1:0] pos,
                              input logic signed [DATA_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    in_cmd      = cmd;
    in_position = pos;
    in_value    = val;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_command(cmd, pos, val));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Hold until every predicted result has been seen
  task automatic settle_results();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] cap);
    settle_results();
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = cap;
    do @(posedge clk); while (!cfg_ready);
    model_cap = cap;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic clear_list();
    while (model_len > 0) send_command(CMD_DELETE, CNT_W'(1), $urandom());
  endtask

  // Empty-list failures, boundary positions, extreme values, first match
  task automatic test_edge_cases();
    send_command(CMD_GET,    8'd1,   32'sd0);
    send_command(CMD_DELETE, 8'd0,   32'sd0);
    send_command(CMD_LOCATE, 8'd0,   32'sd0);
    send_command(CMD_INSERT, 8'd0,   32'sd5);
    send_command(CMD_INSERT, 8'd2,   32'sd5);
    send_command(CMD_INSERT, 8'd1,   32'h8000_0000);
    send_command(CMD_INSERT, 8'd2,   32'h7FFF_FFFF);
    send_command(CMD_INSERT, 8'd1,   -32'sd1);
    send_command(CMD_INSERT, 8'd3,   32'sd0);
    send_command(CMD_INSERT, 8'd5,   -32'sd1);
    send_command(CMD_GET,    8'd1,   32'sd0);
    send_command(CMD_GET,    8'd5,   32'sd0);
    send_command(CMD_GET,    8'd6,   32'sd0);
    send_command(CMD_GET,    8'd255, 32'sd0);
    send_command(CMD_GET,    8'd0,   32'sd0);
    send_command(CMD_LOCATE, 8'd0,   -32'sd1);
    send_command(CMD_LOCATE, 8'd255, 32'h7FFF_FFFF);
    send_command(CMD_LOCATE, 8'd1,   32'sd12345);
    send_command(CMD_INSERT, 8'd255, 32'sd9);
    send_command(CMD_DELETE, 8'd6,   32'sd0);
    send_command(CMD_DELETE, 8'd3,   32'sd0);
    send_command(CMD_DELETE, 8'd4,   32'sd0);
    send_command(CMD_DELETE, 8'd1,   32'sd0);
    send_command(CMD_LOCATE, 8'd0,   -32'sd1);
    send_command(CMD_GET,    8'd2,   32'sd0);
  endtask

  // Zero and one-entry capacity, capacity lowered below the length, top value
  task automatic test_capacity_limit();
    clear_list();
    write_capacity(8'd0);
    send_command(CMD_INSERT, 8'd1, 32'sd11);
    send_command(CMD_LOCATE, 8'd0, 32'sd11);
    write_capacity(8'd1);
    send_command(CMD_INSERT, 8'd1, 32'sd11);
    send_command(CMD_INSERT, 8'd2, 32'sd22);
    send_command(CMD_INSERT, 8'd1, 32'sd33);
    send_command(CMD_GET,    8'd1, 32'sd0);
    write_capacity(8'd128);
    for (int i = 2; i <= 5; i++) send_command(CMD_INSERT, CNT_W'(i), 32'(i * 11));
    write_capacity(8'd2);
    send_command(CMD_INSERT, 8'd6, 32'sd66);
    send_command(CMD_GET,    8'd5, 32'sd0);
    send_command(CMD_DELETE, 8'd1, 32'sd0);
    send_command(CMD_INSERT, 8'd1, 32'sd77);
    send_command(CMD_LOCATE, 8'd0, 32'sd55);
    write_capacity(8'd255);
    send_command(CMD_INSERT, 8'd1, 32'sd88);
  endtask

  // Fill the whole store, probe the far end, then shift everything out
  task automatic test_full_store();
    while (model_len < DEPTH)
      send_command(CMD_INSERT, CNT_W'($urandom_range(1, model_len + 1)), $urandom());
    send_command(CMD_INSERT, 8'd1,   32'sd1);
    send_command(CMD_INSERT, 8'd129, 32'sd1);
    send_command(CMD_GET,    8'd128, 32'sd0);
    send_command(CMD_LOCATE, 8'd0,   list_model[DEPTH-1]);
    send_command(CMD_LOCATE, 8'd0,   $urandom());
    send_command(CMD_DELETE, 8'd128, 32'sd0);
    send_command(CMD_GET,    8'd128, 32'sd0);
    send_command(CMD_INSERT, 8'd128, 32'h7FFF_FFFF);
    while (model_len > 0)
      send_command(CMD_DELETE, CNT_W'($urandom_range(1, model_len)), $urandom());
  endtask

  // Random commands with a length that drifts around a few dozen entries
  task automatic test_random_traffic(input int n_items, input logic [CNT_W-1:0] cap,
                                     input int send_pct, input int recv_pct,
                                     input bit with_pauses);
    int                       pick;
    int                       ins_w;
    int                       del_w;
    int                       span;
    logic [CMD_W-1:0]         cmd;
    logic [CNT_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    write_capacity(cap);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < n_items; i++) begin
      // pick the command, favouring growth while the list is short
      ins_w = (model_len < 24) ? 45 : 20;
      del_w = (model_len < 24) ? 15 : 40;
      pick  = $urandom_range(0, 99);
      if (pick < ins_w)              cmd = CMD_INSERT;
      else if (pick < ins_w + del_w) cmd = CMD_DELETE;
      else if (pick < 70)            cmd = CMD_GET;
      else                           cmd = CMD_LOCATE;

      // mostly valid positions, with zero, one past the end and noise
      span = (cmd == CMD_INSERT) ? model_len + 1 : model_len;
      case ($urandom_range(0, 11))
        0:       pos = '0;
        1:       pos = CNT_W'($urandom_range(0, 255));
        2:       pos = CNT_W'(span + 1);
        3:       pos = CNT_W'(span);
        default: pos = (span == 0) ? CNT_W'(1) : CNT_W'($urandom_range(1, span));
      endcase

      // values: full range, a small pool, extremes, or one already held
      case ($urandom_range(0, 3))
        0: val = $urandom();
        1: val = $signed(DATA_W'($urandom_range(0, 15))) - 32'sd8;
        2: begin
          case ($urandom_range(0, 3))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7FFF_FFFF;
            2:       val = 32'sd0;
            default: val = -32'sd1;
          endcase
        end
        default: val = (model_len > 0) ? list_model[$urandom_range(0, model_len - 1)]
                                       : $urandom();
      endcase

      send_command(cmd, pos, val);
      if (with_pauses && $urandom_range(0, 39) == 0) settle_results();
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = CMD_GET;
    in_position    = '0;
    in_value       = '0;
    out_ready      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    mismatch_count = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    quiet_cycles   = 0;
    model_len      = 0;
    model_cap      = CAP_RESET;
    foreach (list_model[k]) list_model[k] = '0;

    // hold reset, release on a falling edge
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_edge_cases();
    test_capacity_limit();
    test_full_store();
    test_random_traffic(250, 8'd128, 0,  0,  1'b0);
    test_random_traffic(250, 8'd12,  52, 0,  1'b1);
    test_random_traffic(250, 8'd255, 0,  52, 1'b0);
    test_random_traffic(250, 8'd40,  27, 27, 1'b1);

    // drain, then watch for stray results
    settle_results();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending_results.size() != 0) begin
      mismatch_count += pending_results.size();
      $display("%0d result items never arrived", pending_results.size());
    end
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/ple_pkg.sv
hw/rtl/ple_mem.sv
hw/rtl/ple_seq.sv
hw/rtl/positional_list_engine.sv
tb/tb.sv
